// ===== rtl/core/common_mode_zero_suppression_unit_macros.svh =====
// Assertion macros for the common-mode zero suppression unit.
`ifndef COMMON_MODE_ZERO_SUPPRESSION_UNIT_MACROS_SVH
`define COMMON_MODE_ZERO_SUPPRESSION_UNIT_MACROS_SVH

// Same-cycle implication, checked on clk, off during rst.
`define CMZS_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on clk, off during rst.
`define CMZS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/cmzs_pkg.sv =====
// Types and constants shared by the common-mode zero suppression unit.
package cmzs_pkg;

  localparam int CHANNELS    = 1024;
  localparam int TIME_BINS   = 1024;
  localparam int EV_DEPTH    = 4096;
  localparam int CHAN_W      = $clog2(CHANNELS);
  localparam int BIN_AW      = $clog2(TIME_BINS);
  localparam int EV_AW       = $clog2(EV_DEPTH);
  localparam int QDEPTH      = 4;
  localparam int QAW         = $clog2(QDEPTH);

  localparam logic [10:0] COUNT_MAX = 11'd2047;

  // configuration register indexes
  localparam logic [1:0] REG_FIRST_CHIP = 2'd0;
  localparam logic [1:0] REG_CM_MULT    = 2'd1;
  localparam logic [1:0] REG_HIT_MULT   = 2'd2;
  localparam logic [1:0] REG_ADC_LIMIT  = 2'd3;

  typedef enum logic [1:0] {
    OP_PED    = 2'd0,
    OP_WORD   = 2'd1,
    OP_PULL   = 2'd2,
    OP_IGNORE = 2'd3
  } cmzs_op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_WRD_RD,
    S_WRD_WR,
    S_PULL_CHK,
    S_PULL_EV,
    S_PULL_PB,
    S_PULL_DIV,
    S_PULL_THR,
    S_PULL_CMP
  } cmzs_state_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic [5:0]         chip_number;
    logic [4:0]         chip_channel;
    logic [9:0]         word_position;
    logic signed [15:0] word_value;
    logic [15:0]        strip_position;
    logic [13:0]        pedestal_mean;
    logic [13:0]        pedestal_sigma;
    logic               last_word;
  } cmzs_in_t;

  typedef struct packed {
    logic        hit_valid;
    logic [9:0]  channel_index;
    logic [9:0]  time_bin;
    logic [15:0] amplitude;
    logic [15:0] hit_strip_position;
    logic        event_done;
    logic [31:0] event_number;
    logic [31:0] bad_channels;
  } cmzs_out_t;

  typedef struct packed {
    logic [5:0]  first_chip;
    logic [3:0]  cm_mult;
    logic [3:0]  hit_mult;
    logic [12:0] adc_limit;
  } cmzs_cfg_t;

  typedef struct packed {
    cmzs_op_t           op;
    logic [CHAN_W-1:0]  chan;
    logic [9:0]         pos;
    logic signed [15:0] value;
    logic [15:0]        strip;
    logic [13:0]        mean;
    logic [13:0]        sigma;
  } cmzs_entry_t;

  // buffered event word; value is known to lie in 0..8190
  typedef struct packed {
    logic [12:0]       value;
    logic [CHAN_W-1:0] chan;
    logic [9:0]        pos;
    logic [15:0]       strip;
  } cmzs_ev_t;

  typedef struct packed {
    logic        valid;
    cmzs_entry_t entry;
  } cmzs_qhead_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } cmzs_bctl_t;

  localparam int PED_W = 28;
  localparam int BINR_W = 43;
  localparam int EV_W = $bits(cmzs_ev_t);

endpackage

// ===== rtl/core/cmzs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module cmzs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/cmzs_div.sv =====
// Restoring divider: signed 32-bit sum by 11-bit count, one quotient bit per cycle.
module cmzs_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic [10:0]        divisor,
  output logic               done,
  output logic signed [31:0] quot
);

  logic        busy;
  logic        neg;
  logic [31:0] q;
  logic [10:0] rem;
  logic [10:0] dsr;
  logic [4:0]  cnt;
  logic [11:0] trial;
  logic        ge;
  logic [11:0] diff;

  assign trial = {rem, q[31]};
  assign ge    = trial >= {1'b0, dsr};
  assign diff  = trial - {1'b0, dsr};
  assign quot  = neg ? -$signed(q) : $signed(q);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
        neg  <= dividend[31];
        q    <= dividend[31] ? 32'(-dividend) : 32'(dividend);
        rem  <= '0;
        dsr  <= divisor;
      end else if (busy) begin
        rem <= ge ? diff[10:0] : trial[10:0];
        q   <= {q[30:0], ge};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/core/cmzs_front.sv =====
// Front end: accepts items, maps the global channel, queues work for the back end.
module cmzs_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic [5:0]            first_chip,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  cmzs_pkg::cmzs_in_t    in_data,
  input  cmzs_pkg::cmzs_bctl_t  bctl,
  output cmzs_pkg::cmzs_qhead_t head
);
  import cmzs_pkg::*;

  cmzs_entry_t  q [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;
  logic           push;
  cmzs_entry_t    entry;

  assign in_stall = (count == QAW'(0) + (QAW+1)'(QDEPTH)) || bctl.clearing;
  assign push     = in_valid && !in_stall && (cmzs_op_t'(in_data.operation) != OP_IGNORE);

  // 32 channels per chip: chip offset wraps in its low bits
  always_comb begin
    entry.op    = cmzs_op_t'(in_data.operation);
    entry.chan  = {5'(in_data.chip_number[4:0] - first_chip[4:0]), in_data.chip_channel};
    entry.pos   = in_data.word_position;
    entry.value = in_data.word_value;
    entry.strip = in_data.strip_position;
    entry.mean  = in_data.pedestal_mean;
    entry.sigma = in_data.pedestal_sigma;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + QAW'(1);
      end
      if (bctl.pop) begin
        rd_ptr <= rd_ptr + QAW'(1);
      end
      case ({push, bctl.pop})
        2'b10:   count <= count + (QAW+1)'(1);
        2'b01:   count <= count - (QAW+1)'(1);
        default: count <= count;
      endcase
    end
  end

  assign head.valid = (count != '0);
  assign head.entry = q[rd_ptr];

endmodule

// ===== rtl/core/cmzs_back.sv =====
// Back end: pedestal writes, common-mode accumulation, buffer walk, hit and end-of-event output, bin sweep.
module cmzs_back (
  input  logic                  clk,
  input  logic                  rst,
  input  cmzs_pkg::cmzs_cfg_t   cfg,
  input  cmzs_pkg::cmzs_qhead_t head,
  output cmzs_pkg::cmzs_bctl_t  bctl,
  output logic                  out_valid,
  input  logic                  out_stall,
  output cmzs_pkg::cmzs_out_t   out_data
);
  import cmzs_pkg::*;

  cmzs_state_t state, state_next;
  cmzs_entry_t cur;
  logic        pop;

  logic [EV_AW:0]    stored_words;
  logic [EV_AW:0]    read_pointer;
  logic              skip_flag;
  logic [CHAN_W-1:0] skip_channel;
  logic [31:0]       finished_events;
  logic [31:0]       bad_total;
  logic [BIN_AW-1:0] clr_idx;

  logic              ped_we;
  logic [CHAN_W-1:0] ped_raddr;
  logic [PED_W-1:0]  ped_rdata;
  logic              bin_we;
  logic [BIN_AW-1:0] bin_waddr;
  logic [BINR_W-1:0] bin_wdata;
  logic [BIN_AW-1:0] bin_raddr;
  logic [BINR_W-1:0] bin_rdata;
  logic              ev_we;
  cmzs_ev_t          ev_wdata;
  logic [EV_W-1:0]   ev_rdata;
  cmzs_ev_t          ev_rd;

  // word path
  logic signed [20:0] cm_thr;
  logic signed [20:0] cm_diff;
  logic signed [20:0] v16;
  logic               is_data;
  logic               skip_now;
  logic               bad_word;
  logic               cm_join;
  logic signed [31:0] bin_sum;
  logic [10:0]        bin_count;

  // pull path
  cmzs_ev_t           ev_cur;
  logic [13:0]        p_mean;
  logic [13:0]        p_sigma;
  logic signed [31:0] avg;
  logic signed [33:0] hit_thr;
  logic signed [33:0] hit_amp;
  logic signed [33:0] pv16;
  logic               more;
  logic               is_hit;
  logic [15:0]        amp_sat;

  logic               div_start;
  logic               div_done;
  logic signed [31:0] div_quot;

  assign ev_rd     = cmzs_ev_t'(ev_rdata);
  assign bin_sum   = $signed(bin_rdata[42:11]);
  assign bin_count = bin_rdata[10:0];

  assign pop = (state == S_IDLE) && head.valid &&
               ((head.entry.op != OP_PULL) || !out_valid);
  assign bctl.pop      = pop;
  assign bctl.clearing = (state == S_CLEAR);

  assign v16      = 21'(signed'({cur.value, 4'b0000}));
  assign is_data  = (cur.pos[9:1] != 9'd0);
  assign skip_now = skip_flag && (cur.chan == skip_channel);
  assign bad_word = cur.value[15] || (16'(cur.value) >= {3'b000, cfg.adc_limit});
  assign cm_join  = is_data && (v16 < cm_thr) && (bin_count != COUNT_MAX);
  assign more     = read_pointer < stored_words;
  assign pv16     = $signed({17'd0, ev_cur.value, 4'b0000});
  assign is_hit   = pv16 > hit_thr;

  always_comb begin
    if (hit_amp[33]) begin
      amp_sat = 16'd0;
    end else if (hit_amp[32:16] != 17'd0) begin
      amp_sat = 16'hFFFF;
    end else begin
      amp_sat = hit_amp[15:0];
    end
  end

  always_comb begin
    ev_wdata.value = cur.value[12:0];
    ev_wdata.chan  = cur.chan;
    ev_wdata.pos   = cur.pos;
    ev_wdata.strip = cur.strip;
  end

  cmzs_ram #(.WIDTH(PED_W), .DEPTH(CHANNELS)) u_ped (
    .clk   (clk),
    .we    (ped_we),
    .waddr (head.entry.chan),
    .wdata ({head.entry.mean, head.entry.sigma}),
    .raddr (ped_raddr),
    .rdata (ped_rdata)
  );

  cmzs_ram #(.WIDTH(BINR_W), .DEPTH(TIME_BINS)) u_bin (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  cmzs_ram #(.WIDTH(EV_W), .DEPTH(EV_DEPTH)) u_ev (
    .clk   (clk),
    .we    (ev_we),
    .waddr (stored_words[EV_AW-1:0]),
    .wdata (ev_wdata),
    .raddr (read_pointer[EV_AW-1:0]),
    .rdata (ev_rdata)
  );

  cmzs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (bin_sum),
    .divisor  (bin_count),
    .done     (div_done),
    .quot     (div_quot)
  );

  always_comb begin
    state_next = state;
    ped_we     = 1'b0;
    ped_raddr  = cur.chan;
    bin_we     = 1'b0;
    bin_waddr  = cur.pos[BIN_AW-1:0];
    bin_wdata  = {32'(bin_sum + 32'(cm_diff)), 11'(bin_count + 11'd1)};
    bin_raddr  = cur.pos[BIN_AW-1:0];
    ev_we      = 1'b0;
    div_start  = 1'b0;
    case (state)
      S_CLEAR: begin
        bin_we    = 1'b1;
        bin_waddr = clr_idx;
        bin_wdata = '0;
        if (clr_idx == '1) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        ped_raddr = head.entry.chan;
        bin_raddr = head.entry.pos[BIN_AW-1:0];
        if (pop) begin
          case (head.entry.op)
            OP_PED:  ped_we = 1'b1;
            OP_WORD: state_next = S_WRD_RD;
            OP_PULL: state_next = S_PULL_CHK;
            default: state_next = S_IDLE;
          endcase
        end
      end
      S_WRD_RD: state_next = S_WRD_WR;
      S_WRD_WR: begin
        bin_we = cm_join;
        ev_we  = is_data && !skip_now && !bad_word && !stored_words[EV_AW];
        state_next = S_IDLE;
      end
      S_PULL_CHK: state_next = more ? S_PULL_EV : S_CLEAR;
      S_PULL_EV: begin
        ped_raddr  = ev_rd.chan;
        bin_raddr  = ev_rd.pos[BIN_AW-1:0];
        state_next = S_PULL_PB;
      end
      S_PULL_PB: begin
        if (bin_count != 11'd0) begin
          div_start  = 1'b1;
          state_next = S_PULL_DIV;
        end else begin
          state_next = S_PULL_THR;
        end
      end
      S_PULL_DIV: begin
        if (div_done) begin
          state_next = S_PULL_THR;
        end
      end
      S_PULL_THR: state_next = S_PULL_CMP;
      S_PULL_CMP: state_next = is_hit ? S_IDLE : S_PULL_CHK;
      default:    state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head.entry;
    end
    case (state)
      S_WRD_RD: begin
        cm_thr  <= $signed({2'b00, 19'(ped_rdata[27:14])
                                   + 19'(cfg.cm_mult) * 19'(ped_rdata[13:0])});
        cm_diff <= v16 - $signed({7'd0, ped_rdata[27:14]});
      end
      S_PULL_EV: ev_cur <= ev_rd;
      S_PULL_PB: begin
        p_mean  <= ped_rdata[27:14];
        p_sigma <= ped_rdata[13:0];
        avg     <= '0;
      end
      S_PULL_DIV: begin
        if (div_done) begin
          avg <= div_quot;
        end
      end
      S_PULL_THR: begin
        hit_thr <= $signed({20'd0, p_mean}) + $signed({16'd0, 18'(cfg.hit_mult) * 18'(p_sigma)})
                   + 34'(avg);
        hit_amp <= pv16 - $signed({20'd0, p_mean}) - 34'(avg);
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      stored_words    <= '0;
      read_pointer    <= '0;
      skip_flag       <= 1'b0;
      skip_channel    <= '0;
      finished_events <= '0;
      bad_total       <= '0;
      clr_idx         <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: clr_idx <= clr_idx + BIN_AW'(1);
        S_WRD_WR: begin
          if (is_data && !skip_now && bad_word) begin
            bad_total    <= bad_total + 32'd1;
            skip_flag    <= 1'b1;
            skip_channel <= cur.chan;
          end else begin
            skip_flag <= skip_now;
            if (is_data && !skip_now && !stored_words[EV_AW]) begin
              stored_words <= stored_words + (EV_AW+1)'(1);
            end
          end
        end
        S_PULL_CHK: begin
          if (!more) begin
            // end of event: report, then sweep the bins
            out_valid       <= 1'b1;
            out_data        <= '{hit_valid: 1'b0, channel_index: 10'd0, time_bin: 10'd0,
                                 amplitude: 16'd0, hit_strip_position: 16'd0,
                                 event_done: 1'b1,
                                 event_number: finished_events + 32'd1,
                                 bad_channels: bad_total};
            finished_events <= finished_events + 32'd1;
            stored_words    <= '0;
            read_pointer    <= '0;
            skip_flag       <= 1'b0;
            skip_channel    <= '0;
            clr_idx         <= '0;
          end
        end
        S_PULL_EV: read_pointer <= read_pointer + (EV_AW+1)'(1);
        S_PULL_CMP: begin
          if (is_hit) begin
            out_valid <= 1'b1;
            out_data  <= '{hit_valid: 1'b1, channel_index: 10'(ev_cur.chan),
                           time_bin: ev_cur.pos, amplitude: amp_sat,
                           hit_strip_position: ev_cur.strip, event_done: 1'b0,
                           event_number: finished_events, bad_channels: bad_total};
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/core/common_mode_zero_suppression_unit.sv =====
// Top level of the common-mode zero suppression unit: config registers and assembly.
//
//   channel | handshake           | payload
//   --------+---------------------+--------------------------------
//   input   | in_valid / in_stall | in_data  (cmzs_in_t)
//   output  | out_valid/out_stall | out_data (cmzs_out_t)
//   config  | cfg_write           | cfg_index, cfg_data
//
// Pedestal write: taken in the back end's idle state. Event word: pedestal/bin RAM read,
// threshold, then bin read-modify-write. Pull: walks the buffered words, running the bin
// average divider for a word whose bin is not empty. After reset and after each event_done
// result the bin RAM is swept with in_stall high. A 4-entry queue lets words enter while a
// result waits on out_stall.
module common_mode_zero_suppression_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  cmzs_pkg::cmzs_in_t in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output cmzs_pkg::cmzs_out_t out_data,
  input  logic               cfg_write,
  input  logic [1:0]         cfg_index,
  input  logic [12:0]        cfg_data
);
  import cmzs_pkg::*;

  cmzs_cfg_t   cfg;
  cmzs_qhead_t head;
  cmzs_bctl_t  bctl;
  logic        in_take;

  assign in_take = in_valid && !in_stall && (in_data.operation != OP_IGNORE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.first_chip <= 6'd8;
      cfg.cm_mult    <= 4'd3;
      cfg.hit_mult   <= 4'd4;
      cfg.adc_limit  <= 13'd1024;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_FIRST_CHIP: cfg.first_chip <= cfg_data[5:0];
        REG_CM_MULT:    cfg.cm_mult    <= cfg_data[3:0];
        REG_HIT_MULT:   cfg.hit_mult   <= cfg_data[3:0];
        REG_ADC_LIMIT:  cfg.adc_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  cmzs_front u_front (
    .clk        (clk),
    .rst        (rst),
    .first_chip (cfg.first_chip),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .bctl       (bctl),
    .head       (head)
  );

  cmzs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .head      (head),
    .bctl      (bctl),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

`include "common_mode_zero_suppression_unit_macros.svh"

  `CMZS_ASSERT_NOW(a_clear_blocks_input, bctl.clearing, in_stall, "item taken during bin sweep")
  `CMZS_ASSERT_NOW(a_pop_needs_entry, bctl.pop, head.valid, "pop from empty queue")
  `CMZS_ASSERT_NOW(a_sweep, $rose(out_valid) && out_data.event_done, bctl.clearing, "no sweep")
  `CMZS_ASSERT_NEXT(a_push_fills_queue, in_take, head.valid, "queued transaction lost")

endmodule

// ===== bench/common_mode_zero_suppression_unit_test.sv =====
// Self-checking testbench for the common-mode zero suppression unit.
module common_mode_zero_suppression_unit_test;
  timeunit 1ns;
  timeprecision 1ps;
  import cmzs_pkg::*;

  localparam int CYCLE_LIMIT = 10_000_000;
  localparam int SWEEP_WAIT  = 1200;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  cmzs_in_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  cmzs_out_t   out_data;
  logic        cfg_write = 1'b0;
  logic [1:0]  cfg_index = REG_FIRST_CHIP;
  logic [12:0] cfg_data = '0;

  common_mode_zero_suppression_unit u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the unit's state
  int  ped_mean [CHANNELS];
  int  ped_sigma [CHANNELS];
  bit  ped_ok [CHANNELS];
  int  ev_val [EV_DEPTH];
  int  ev_chan [EV_DEPTH];
  int  ev_pos [EV_DEPTH];
  int  ev_strip [EV_DEPTH];
  int  bin_sum [TIME_BINS];
  int  bin_cnt [TIME_BINS];
  int  n_stored, rd_ptr, skip_ch;
  bit  skipping;
  int unsigned done_events, bad_total;
  int  first_chip_r = 8, cm_mult_r = 3, hit_mult_r = 4, adc_limit_r = 1024;

  cmzs_out_t hit_q[$];
  int  errors, sent_items, hit_count;
  int  send_idle = 12, recv_idle = 58;
  bit  event_over;
  longint cycles;

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("FAIL");
      $finish;
    end
  end

  always @(posedge clk) out_stall <= (recv_idle > 0) && ($urandom_range(99) < recv_idle);

  function automatic int global_chan(int chip, int ch);
    int g;
    g = 32 * (chip - first_chip_r) + ch;
    g = g % CHANNELS;
    if (g < 0) g += CHANNELS;
    return g;
  endfunction

  function automatic void clear_event_state();
    for (int i = 0; i < TIME_BINS; i++) begin
      bin_sum[i] = 0;
      bin_cnt[i] = 0;
    end
    n_stored = 0;
    rd_ptr = 0;
    skipping = 0;
    skip_ch = 0;
  endfunction

  function automatic void take_word(cmzs_in_t it);
    int g, pos, val, v16, bin;
    g = global_chan(it.chip_number, it.chip_channel);
    pos = it.word_position;
    val = $signed(it.word_value);
    if (skipping && g != skip_ch) skipping = 0;
    if (pos < 2) return;
    bin = pos % TIME_BINS;
    v16 = val * 16;
    if (v16 < ped_mean[g] + cm_mult_r * ped_sigma[g] && bin_cnt[bin] < COUNT_MAX) begin
      bin_sum[bin] += v16 - ped_mean[g];
      bin_cnt[bin]++;
    end
    if (skipping) return;
    if (val < 0 || val >= adc_limit_r) begin
      bad_total++;
      skipping = 1;
      skip_ch = g;
      return;
    end
    if (n_stored < EV_DEPTH) begin
      ev_val[n_stored] = val;
      ev_chan[n_stored] = g;
      ev_pos[n_stored] = pos;
      ev_strip[n_stored] = it.strip_position;
      n_stored++;
    end
  endfunction

  function automatic cmzs_out_t next_hit();
    cmzs_out_t r;
    int avg, bin, g, v16, amp;
    r = '0;
    while (rd_ptr < n_stored) begin
      bin = ev_pos[rd_ptr] % TIME_BINS;
      avg = (bin_cnt[bin] == 0) ? 0 : bin_sum[bin] / bin_cnt[bin];
      g = ev_chan[rd_ptr];
      v16 = ev_val[rd_ptr] * 16;
      rd_ptr++;
      if (v16 > ped_mean[g] + hit_mult_r * ped_sigma[g] + avg) begin
        amp = v16 - ped_mean[g] - avg;
        if (amp < 0) amp = 0;
        if (amp > 65535) amp = 65535;
        r.hit_valid = 1'b1;
        r.channel_index = 10'(g);
        r.time_bin = 10'(ev_pos[rd_ptr - 1]);
        r.amplitude = 16'(amp);
        r.hit_strip_position = 16'(ev_strip[rd_ptr - 1]);
        r.event_number = done_events;
        r.bad_channels = bad_total;
        return r;
      end
    end
    done_events++;
    clear_event_state();
    r.event_done = 1'b1;
    r.event_number = done_events;
    r.bad_channels = bad_total;
    return r;
  endfunction

  function automatic void check_field(string nm, longint unsigned e, longint unsigned a);
    if (e != a) begin
      errors++;
      $display("%0t mismatch %s: expected %0d, got %0d", $time, nm, e, a);
    end
  endfunction

  // handshake completes at the next rising edge; decide at the falling edge
  always @(negedge clk) begin
    cmzs_out_t e;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      if (hit_q.size() == 0) begin
        errors++;
        $display("%0t unexpected transaction: got %h", $time, out_data);
      end else begin
        e = hit_q.pop_front();
        check_field("hit_valid", e.hit_valid, out_data.hit_valid);
        check_field("channel_index", e.channel_index, out_data.channel_index);
        check_field("time_bin", e.time_bin, out_data.time_bin);
        check_field("amplitude", e.amplitude, out_data.amplitude);
        check_field("hit_strip_position", e.hit_strip_position, out_data.hit_strip_position);
        check_field("event_done", e.event_done, out_data.event_done);
        check_field("event_number", e.event_number, out_data.event_number);
        check_field("bad_channels", e.bad_channels, out_data.bad_channels);
      end
    end
  end

  task automatic send_item(input cmzs_in_t it);
    cmzs_out_t r;
    bit ready;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do begin
      @(negedge clk);
      ready = (in_stall === 1'b0);
      @(posedge clk);
    end while (!ready);
    case (cmzs_op_t'(it.operation))
      OP_PED: begin
        ped_mean[global_chan(it.chip_number, it.chip_channel)] = it.pedestal_mean;
        ped_sigma[global_chan(it.chip_number, it.chip_channel)] = it.pedestal_sigma;
        ped_ok[global_chan(it.chip_number, it.chip_channel)] = 1'b1;
      end
      OP_WORD: take_word(it);
      OP_PULL: begin
        r = next_hit();
        hit_q = {hit_q, r};
        event_over = r.event_done;
        if (r.hit_valid) hit_count++;
      end
      default: ;
    endcase
    if (cmzs_op_t'(it.operation) != OP_IGNORE) sent_items++;
  endtask

  task automatic put_ped(int chip, int ch, int mean, int sigma);
    cmzs_in_t it;
    it = '0;
    it.operation = OP_PED;
    it.chip_number = 6'(chip);
    it.chip_channel = 5'(ch);
    it.pedestal_mean = 14'(mean);
    it.pedestal_sigma = 14'(sigma);
    it.last_word = 1'($urandom_range(1));
    send_item(it);
  endtask

  // pedestal entry of a channel is always written before its first word
  task automatic send_word(int chip, int ch, int pos, int val);
    cmzs_in_t it;
    if (!ped_ok[global_chan(chip, ch)])
      put_ped(chip, ch, $urandom_range(0, 4800), $urandom_range(0, 48));
    it = '0;
    it.operation = OP_WORD;
    it.chip_number = 6'(chip);
    it.chip_channel = 5'(ch);
    it.word_position = 10'(pos);
    it.word_value = val[15:0];
    it.strip_position = 16'($urandom_range(0, 65535));
    it.last_word = 1'($urandom_range(1));
    send_item(it);
  endtask

  task automatic send_pull();
    cmzs_in_t it;
    it = '0;
    it.operation = OP_PULL;
    send_item(it);
  endtask

  task automatic pull_to_end();
    event_over = 0;
    do send_pull(); while (!event_over);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (hit_q.size() != 0);
  endtask

  // close the event, let the bin sweep finish, then reprogram
  task automatic write_regs(int fc, int cm, int hm, int lim);
    pull_to_end();
    drain();
    repeat (SWEEP_WAIT) @(posedge clk);
    cfg_write <= 1'b1; cfg_index <= REG_FIRST_CHIP; cfg_data <= 13'(fc);
    @(posedge clk);
    cfg_index <= REG_CM_MULT; cfg_data <= 13'(cm);
    @(posedge clk);
    cfg_index <= REG_HIT_MULT; cfg_data <= 13'(hm);
    @(posedge clk);
    cfg_index <= REG_ADC_LIMIT; cfg_data <= 13'(lim);
    @(posedge clk);
    cfg_write <= 1'b0;
    first_chip_r = fc; cm_mult_r = cm; hit_mult_r = hm; adc_limit_r = lim;
  endtask

  function automatic int pick_value(int g, int kind);
    int v;
    if (kind == 2)
      return $urandom_range(1) ? -$urandom_range(1, 32768)
                               : adc_limit_r + $urandom_range(0, 32767 - adc_limit_r);
    if (kind == 1)
      v = (ped_mean[g] + hit_mult_r * ped_sigma[g]) / 16 + $urandom_range(2, 60);
    else
      v = ped_mean[g] / 16 + $urandom_range(0, 4) - 2;
    if (v < 0) v = 0;
    if (v > adc_limit_r - 1) v = adc_limit_r - 1;
    return v;
  endfunction

  task automatic run_event(int nchan, int nwords, int hit_pct, int bad_pct);
    int chip, ch, g, base, pos, kind, r;
    for (int c = 0; c < nchan; c++) begin
      chip = $urandom_range(0, 63);
      ch = $urandom_range(0, 31);
      g = global_chan(chip, ch);
      base = ($urandom_range(9) == 0) ? 1010 : 0;
      for (int p = 0; p < nwords + 2; p++) begin
        pos = (p < 2) ? p : ((base + p > 1023) ? 1023 : base + p);
        r = $urandom_range(99);
        kind = (r < bad_pct) ? 2 : (r < bad_pct + hit_pct) ? 1 : 0;
        if (!ped_ok[g]) put_ped(chip, ch, $urandom_range(0, 4800), $urandom_range(0, 48));
        send_word(chip, ch, pos, pick_value(g, kind));
      end
    end
    pull_to_end();
  endtask

  task automatic test_directed_cases();
    cmzs_in_t it;
    put_ped(8, 0, 1600, 16);
    put_ped(8, 1, 0, 0);
    send_word(8, 0, 0, 1000);    // headers stay out of buffer and common mode
    send_word(8, 0, 1, 0);
    send_word(8, 0, 2, 100);
    send_word(8, 0, 3, 101);
    send_word(8, 0, 4, 200);     // hit in an empty bin
    send_word(8, 0, 5, -5);      // bad channel, rest of channel skipped
    send_word(8, 0, 6, 2000);
    send_word(8, 1, 2, 1023);    // new channel ends the skip
    send_word(8, 1, 3, 1024);
    it = '0;
    it.operation = OP_IGNORE;
    it.word_value = 16'hffff;
    send_item(it);
    send_pull();
    send_word(8, 1, 1023, 900);  // appended after a pull
    pull_to_end();
    send_pull();                 // pull on an empty event
  endtask

  task automatic test_config_extremes();
    write_regs(0, 0, 0, 1);
    run_event(2, 4, 30, 20);
    write_regs(63, 15, 15, 4096);
    put_ped(63, 0, 16383, 0);
    put_ped(63, 1, 0, 0);
    send_word(63, 0, 7, 0);      // drives the bin average far negative
    send_word(63, 1, 7, 4095);   // amplitude saturates
    send_word(63, 1, 8, 4096);
    pull_to_end();
    run_event(3, 6, 40, 10);
    write_regs(8, 3, 4, 1024);
  endtask

  // one bin loaded with many common-mode words, then hits above its average
  task automatic test_crowded_bin();
    for (int c = 0; c < 32; c++) put_ped(8, c, 160, 16);
    for (int i = 0; i < 200; i++)
      send_word(8, i % 32, 5, (i < 120) ? 10 : (i < 180) ? 0 : 17);
    pull_to_end();
  endtask

  task automatic test_random_traffic();
    cmzs_in_t it;
    int start, r;
    for (int m = 0; m < 3; m++) begin
      send_idle = (m == 0) ? 12 : (m == 1) ? 58 : 0;
      recv_idle = (m == 0) ? 58 : (m == 1) ? 12 : 0;
      write_regs($urandom_range(0, 63), $urandom_range(0, 15), $urandom_range(0, 15),
                 $urandom_range(1, 4096));
      start = sent_items;
      while (sent_items - start < 230) begin
        r = $urandom_range(99);
        if (r < 80) begin
          run_event($urandom_range(1, 3), $urandom_range(1, 10), 25, 8);
        end else if (r < 84) begin
          drain();
        end else begin
          it = '0;
          it.operation = 2'($urandom_range(0, 3));
          it.chip_number = 6'($urandom_range(0, 63));
          it.chip_channel = 5'($urandom_range(0, 31));
          case (cmzs_op_t'(it.operation))
            OP_PED: put_ped(it.chip_number, it.chip_channel,
                            $urandom_range(0, 16383), $urandom_range(0, 16383));
            OP_WORD: send_word(it.chip_number, it.chip_channel,
                               $urandom_range(0, 1023), $urandom_range(0, 65535));
            OP_PULL: send_pull();
            default: begin
              it.word_value = 16'($urandom_range(0, 65535));
              send_item(it);
            end
          endcase
        end
      end
      if (m == 1) write_regs(8, 3, 4, 1024);
    end
  endtask

  initial begin
    clear_event_state();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (SWEEP_WAIT) @(posedge clk);
    test_directed_cases();
    test_config_extremes();
    test_crowded_bin();
    test_random_traffic();
    drain();
    repeat (2000) @(posedge clk);
    $display("%0d items sent, %0d hits and %0d finished events predicted, %0d bad channels",
             sent_items, hit_count, done_events, bad_total);
    $display("covered headers, skips, saturation, a crowded bin and config extremes");
    if (errors == 0 && hit_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("%0d errors, %0d results missing", errors, hit_q.size());
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl/core
rtl/core/cmzs_pkg.sv
rtl/core/cmzs_ram.sv
rtl/core/cmzs_div.sv
rtl/core/cmzs_front.sv
rtl/core/cmzs_back.sv
rtl/core/common_mode_zero_suppression_unit.sv
bench/common_mode_zero_suppression_unit_test.sv
